// ===== sv/seven_segment_scan_display_macros.svh =====
// Assertion macros for the seven-segment scan display block.
`ifndef SEVEN_SEGMENT_SCAN_DISPLAY_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DISPLAY_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");

`endif

// ===== sv/ssd_pkg.sv =====
// Shared types, constants and functions of the seven-segment scan display.
`default_nettype none

package ssd_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int MAX_DIGITS     = 8;
    localparam int VALUE_W        = 16;
    localparam int HALF_W         = VALUE_W / 2;
    localparam int SEL_W          = 3;
    localparam int SEG_W          = 8;
    localparam int BCD_DIGITS     = 5;
    localparam int BCD_W          = 4 * BCD_DIGITS;

    localparam logic [SEG_W-1:0] UNIT_GLYPH = 8'h3e;
    localparam logic [SEG_W-1:0] POINT_BIT  = 8'h80;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_LOAD = 1'b1
    } action_t;

    // Segment pattern of one decimal digit, a..g in bits 0..6.
    function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] dig);
        logic [SEG_W-1:0] g;
        case (dig)
            4'd0:    g = 8'h3f;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5b;
            4'd3:    g = 8'h4f;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6d;
            4'd6:    g = 8'h7d;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7f;
            4'd9:    g = 8'h6f;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

    // Eight shift-and-add-3 steps: shifts one byte, MSB first, into a BCD accumulator.
    function automatic logic [BCD_W-1:0] dabble_byte(input logic [BCD_W-1:0] bcd_in,
                                                     input logic [HALF_W-1:0] bits_in);
        logic [BCD_W-1:0] acc;
        acc = bcd_in;
        for (int b = HALF_W - 1; b >= 0; b--) begin
            for (int d = 0; d < BCD_DIGITS; d++) begin
                if (acc[4*d +: 4] >= 4'd5) begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits_in[b]};
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssd_in_if.sv =====
// Command channel: scan tick or load of a new value.
`default_nettype none

interface ssd_in_if;
    logic                             valid;
    logic                             ready;
    ssd_pkg::action_t                 action;
    logic [ssd_pkg::VALUE_W-1:0]      value;

    modport source (output valid, action, value, input ready);
    modport sink   (input valid, action, value, output ready);
endinterface

`default_nettype wire

// ===== sv/ssd_out_if.sv =====
// Scan channel: digit position and its segment byte.
`default_nettype none

interface ssd_out_if;
    logic                             valid;
    logic                             ready;
    logic [ssd_pkg::SEL_W-1:0]        digit_select;
    logic [ssd_pkg::SEG_W-1:0]        segments;

    modport source (output valid, digit_select, segments, input ready);
    modport sink   (input valid, digit_select, segments, output ready);
endinterface

`default_nettype wire

// ===== sv/ssd_seg_buffer.sv =====
// Segment buffer: builds glyphs with leading-zero blanking from BCD and serves scan reads.
`default_nettype none

module ssd_seg_buffer #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input  wire                                             clk,
    input  wire                                             rst_n,
    input  wire                                             wr_en,
    input  wire  [ssd_pkg::BCD_W-1:0]                       bcd,
    input  wire  [((NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1)-1:0] rd_pos,
    output logic [ssd_pkg::SEG_W-1:0]                       rd_seg
);

    // digit 0 holds the unit glyph, so only MAX_DIGITS-1 decimal digits are ever read
    localparam int EXT_W = 4 * (ssd_pkg::MAX_DIGITS - 1);

    logic [ssd_pkg::SEG_W-1:0] buf_reg  [NUM_DIGITS];
    logic [ssd_pkg::SEG_W-1:0] buf_next [NUM_DIGITS];
    logic [EXT_W-1:0]          bcd_ext;

    assign bcd_ext = EXT_W'(bcd);

    // Digit k shows decimal digit k-1; walk down from the top to find the first nonzero.
    always_comb
    begin
        logic       seen;
        logic [3:0] dig;
        seen        = 1'b0;
        dig         = 4'd0;
        buf_next[0] = ssd_pkg::UNIT_GLYPH;
        for (int k = NUM_DIGITS - 1; k >= 1; k--) begin
            dig         = bcd_ext[4*(k-1) +: 4];
            seen        = seen || (dig != 4'd0) || (k == 1);
            buf_next[k] = seen ? ssd_pkg::digit_glyph(dig) : '0;
        end
        // point on digit 2 even when blanked
        buf_next[2] = buf_next[2] | ssd_pkg::POINT_BIT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                buf_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NUM_DIGITS; i++) begin
                buf_reg[i] <= buf_next[i];
            end
        end
    end

    assign rd_seg = buf_reg[rd_pos];

endmodule

`default_nettype wire

// ===== sv/seven_segment_scan_display.sv =====
// Seven-segment scan display: command pipeline, BCD conversion and scan output.
//
// Channels: cmd (sink) carries action and value; a load item (action = 1)
// converts value to decimal and rebuilds the segment buffer, a tick item
// (action = 0) produces one scan item with digit_select and segments, then
// advances the scan position 0 .. NUM_DIGITS-1, wrapping to 0.
// Digit 0 shows the unit glyph, digits 1 and up the decimal digits with
// leading zeros blanked down to digit 2; digit 2 always has the point.
// A tick item passes the input register, the conversion register and the
// result register, in that order, on its way to scan. A load item
// produces nothing on scan and affects every tick accepted after it.
// Throughput: one item per cycle; the binary-to-BCD conversion is split in
// two halves of eight shift-and-add-3 steps, one per pipeline stage.
// When scan stalls, the result register holds and the stages fill up; cmd
// ready drops only once every stage holds an item that cannot move.
// Reset: all stages empty, segment buffer all zero, scan position 0.
`default_nettype none
`include "seven_segment_scan_display_macros.svh"

module seven_segment_scan_display #(
    parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
    input wire        clk,
    input wire        rst_n,
    ssd_in_if.sink    cmd,
    ssd_out_if.source scan
);

    localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // stage 0: accepted item
    logic                              s0_valid_reg;
    ssd_pkg::action_t                  s0_action_reg;
    logic [ssd_pkg::VALUE_W-1:0]       s0_value_reg;
    // stage 1: upper byte converted, lower byte pending
    logic                              s1_valid_reg;
    ssd_pkg::action_t                  s1_action_reg;
    logic [ssd_pkg::BCD_W-1:0]         s1_bcd_reg;
    logic [ssd_pkg::HALF_W-1:0]        s1_low_reg;
    // result register
    logic                              out_valid_reg;
    logic [ssd_pkg::SEL_W-1:0]         out_sel_reg;
    logic [ssd_pkg::SEG_W-1:0]         out_seg_reg;

    logic [IDX_W-1:0]                  scan_pos_reg;
    logic [IDX_W-1:0]                  scan_pos_next;

    logic                              out_free;
    logic                              s1_is_load;
    logic                              s1_fire;
    logic                              s1_free;
    logic                              s0_free;
    logic                              s0_move;
    logic                              cmd_fire;
    logic                              load_fire;
    logic                              tick_fire;
    logic [ssd_pkg::BCD_W-1:0]         full_bcd;
    logic [ssd_pkg::SEG_W-1:0]         rd_seg;

    assign out_free   = !out_valid_reg || scan.ready;
    assign s1_is_load = (s1_action_reg == ssd_pkg::ACT_LOAD);
    // a load never needs the result register
    assign s1_fire    = s1_valid_reg && (s1_is_load || out_free);
    assign s1_free    = !s1_valid_reg || s1_fire;
    assign s0_free    = !s0_valid_reg || s1_free;
    assign s0_move    = s0_valid_reg && s1_free;
    assign cmd.ready  = s0_free;
    assign cmd_fire   = cmd.valid && s0_free;
    assign load_fire  = s1_fire && s1_is_load;
    assign tick_fire  = s1_fire && !s1_is_load;

    assign full_bcd   = ssd_pkg::dabble_byte(s1_bcd_reg, s1_low_reg);

    always_comb
    begin
        if (scan_pos_reg == IDX_W'(NUM_DIGITS - 1))
        begin
            scan_pos_next = '0;
        end
        else
        begin
            scan_pos_next = scan_pos_reg + 1'b1;
        end
    end

    ssd_seg_buffer #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_seg_buffer (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (load_fire),
        .bcd    (full_bcd),
        .rd_pos (scan_pos_reg),
        .rd_seg (rd_seg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_pos_reg  <= '0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= cmd.valid;
            end
            if (s1_free)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= tick_fire;
            end
            if (tick_fire)
            begin
                scan_pos_reg <= scan_pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s0_action_reg <= cmd.action;
            s0_value_reg  <= cmd.value;
        end
        if (s0_move)
        begin
            s1_action_reg <= s0_action_reg;
            s1_bcd_reg    <= ssd_pkg::dabble_byte('0,
                                 s0_value_reg[ssd_pkg::VALUE_W-1:ssd_pkg::HALF_W]);
            s1_low_reg    <= s0_value_reg[ssd_pkg::HALF_W-1:0];
        end
        if (tick_fire)
        begin
            out_sel_reg <= ssd_pkg::SEL_W'(scan_pos_reg);
            out_seg_reg <= rd_seg;
        end
    end

    assign scan.valid        = out_valid_reg;
    assign scan.digit_select = out_sel_reg;
    assign scan.segments     = out_seg_reg;

    `SSD_ASSERT_NEXT(a_tick_lands_in_result, tick_fire,
        scan.valid && (scan.digit_select == ssd_pkg::SEL_W'($past(scan_pos_reg))))
    `SSD_ASSERT_NEXT(a_pos_moves_on_tick_only, !tick_fire, $stable(scan_pos_reg))
    `SSD_ASSERT_NOW(a_stall_only_when_full, !cmd.ready, s0_valid_reg && s1_valid_reg)

endmodule

`default_nettype wire
